### hdl/rc_pwm_pulse_width_capture_unit_assert.svh
// Assertion macros shared by the RC PWM pulse width capture unit.
`ifndef RC_PWM_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH
`define RC_PWM_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define RPWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define RPWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rpwc_pkg.sv
// Package with the shared constants and types of the RC PWM pulse width capture unit.
`timescale 1ns / 1ps
`default_nettype none

package rpwc_pkg;

    localparam int NumChannels = 4;
    localparam int TickW       = 16;
    localparam int PeriodW     = TickW + 1;
    localparam int ProdW       = 32;
    localparam int RecipW      = 31;
    localparam int QuotW       = 28;
    localparam int SampleW     = 30;
    localparam int WidthW      = 32;

    localparam logic [TickW-1:0]  PrescalerReset = 16'd99;
    localparam logic [TickW-1:0]  TickMax        = 16'hFFFF;
    // Reciprocal of 25 scaled by 2^35; exact for every 32-bit dividend.
    localparam logic [RecipW-1:0] RecipDiv25     = 31'd1374389535;
    localparam int                RecipShift     = 35;
    localparam logic [7:0]        DivBase        = 8'd25;

    typedef logic [NumChannels-1:0][TickW-1:0]   t_tick_vec;
    typedef logic [NumChannels-1:0][SampleW-1:0] t_sample_vec;
    typedef logic [NumChannels-1:0][WidthW-1:0]  t_width_vec;

    // Load enables of the conversion stages behind the edge stage.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

`default_nettype wire

### hdl/rpwc_edge_capture.sv
// Per-channel edge detection, rise time and raw width tracking with the first pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_edge_capture
    import rpwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic                   i_load,
    input  wire logic [NumChannels-1:0] i_levels,
    input  wire t_tick_vec              i_capture,
    output t_tick_vec                   o_raw,
    output logic [NumChannels-1:0]      o_in_range,
    output logic                        o_all
);

    logic [NumChannels-1:0] r_last_level;
    logic [NumChannels-1:0] r_chan_ready;
    t_tick_vec              r_rise_time;
    t_tick_vec              r_raw_width;

    logic [NumChannels-1:0] n_chan_ready;
    t_tick_vec              n_rise_time;
    t_tick_vec              n_raw_width;
    logic [NumChannels-1:0] w_in_range;

    always_comb begin
        for (int i = 0; i < NumChannels; i++) begin
            n_rise_time[i]  = r_rise_time[i];
            n_raw_width[i]  = r_raw_width[i];
            n_chan_ready[i] = r_chan_ready[i];
            if (i_levels[i] && !r_last_level[i]) begin
                n_rise_time[i] = i_capture[i];
            end else if (!i_levels[i] && r_last_level[i]) begin
                n_raw_width[i]  = i_capture[i] - r_rise_time[i];
                n_chan_ready[i] = 1'b1;
            end
            w_in_range[i] = (n_raw_width[i] != '0) && (n_raw_width[i] != TickMax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= '0;
            r_chan_ready <= '0;
            r_rise_time  <= '0;
            r_raw_width  <= '0;
        end else if (i_accept) begin
            // Either edge leaves the stored level equal to the pin.
            r_last_level <= i_levels;
            r_chan_ready <= n_chan_ready;
            r_rise_time  <= n_rise_time;
            r_raw_width  <= n_raw_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_raw      <= n_raw_width;
            o_in_range <= w_in_range;
            o_all      <= &n_chan_ready;
        end
    end

endmodule

`default_nettype wire

### hdl/rpwc_tick_convert.sv
// Three-stage conversion of one channel's tick count to sixteenths of a microsecond.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_tick_convert
    import rpwc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_pipe_en           i_en,
    input  wire logic [TickW-1:0]   i_ticks,
    input  wire logic [PeriodW-1:0] i_period,
    output logic [SampleW-1:0]      o_sample
);

    // sample = floor((16*t*p + 50) / 100) = 4*q + floor((4*r + 12) / 25),
    // where q and r are the quotient and remainder of t*p by 25.
    logic [ProdW-1:0]          r_prod;
    logic [QuotW-1:0]          r_quot;
    logic [7:0]                r_prod_lo;
    logic [PeriodW+TickW-1:0]  w_prod_full;
    logic [ProdW+RecipW-1:0]   w_recip;
    logic [7:0]                w_rem;
    logic [2:0]                w_corr;

    assign w_prod_full = (PeriodW+TickW)'(i_ticks) * (PeriodW+TickW)'(i_period);
    assign w_recip     = (ProdW+RecipW)'(r_prod) * (ProdW+RecipW)'(RecipDiv25);

    // Only the low byte matters: the remainder always lies in 0 to 24.
    assign w_rem = r_prod_lo - 8'(r_quot[7:0] * DivBase);

    always_comb begin
        w_corr = 3'd0;
        if (w_rem >= 8'd4)  w_corr = 3'd1;
        if (w_rem >= 8'd10) w_corr = 3'd2;
        if (w_rem >= 8'd16) w_corr = 3'd3;
        if (w_rem >= 8'd22) w_corr = 3'd4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            // The product of a 16-bit count and a 17-bit period stays below 2^32.
            r_prod <= w_prod_full[ProdW-1:0];
        end
        if (i_en.s3) begin
            r_quot    <= w_recip[RecipShift+QuotW-1:RecipShift];
            r_prod_lo <= r_prod[7:0];
        end
        if (i_en.s4) begin
            o_sample <= {r_quot, 2'b00} + SampleW'(w_corr);
        end
    end

endmodule

`default_nettype wire

### hdl/rpwc_filter_out.sv
// Smoothing filter state of all channels, which also serves as the result register.
`timescale 1ns / 1ps
`default_nettype none

module rpwc_filter_out
    import rpwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [NumChannels-1:0] i_update,
    input  wire t_sample_vec            i_sample,
    output t_width_vec                  o_width
);

    t_width_vec n_width;

    always_comb begin
        logic [WidthW+1:0] sum;
        logic [WidthW+1:0] triple;
        for (int i = 0; i < NumChannels; i++) begin
            triple = (WidthW+2)'(i_sample[i]) + (WidthW+2)'({i_sample[i], 1'b0});
            sum    = (WidthW+2)'(o_width[i]) + triple + (WidthW+2)'(2);
            // A quarter of this sum always fits the 32-bit result, so it never saturates.
            n_width[i] = i_update[i] ? sum[WidthW+1:2] : o_width[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_width <= '0;
        end else if (i_load) begin
            o_width <= n_width;
        end
    end

endmodule

`default_nettype wire

### hdl/rc_pwm_pulse_width_capture_unit.sv
// Top level of the four-channel RC PWM pulse width capture unit.
// Usage:
// Each slave-side transaction is one capture event: the four pin levels and the
// four captured counter values. Every event yields exactly one master-side
// transaction carrying the all_seen flag and the four filtered widths in
// sixteenths of a microsecond. A rise on a pin latches its capture value; a fall
// stores the wrapped 16-bit width and marks the channel ready. Once all four
// channels are ready, each in-range width is converted and folded into its filter.
// The prescaler is written through the cfg channel, which is always ready, and
// must only be written while no event is in flight.
// Throughput is one transaction per cycle while the receiver accepts results.
// An accepted event passes the edge stage, the tick times period multiply, the
// reciprocal multiply for the divide by 25 and the remainder correction, each
// behind a register, and then the filter register before its result is valid.
// Synchronous active-low reset clears all channel state and the filters and sets
// the prescaler to 99. When the receiver stalls, the result holds in the output
// register and the stages behind it keep filling; s_tready drops only once every
// stage is occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_pwm_pulse_width_capture_unit_assert.svh"

module rc_pwm_pulse_width_capture_unit
    import rpwc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Slave side: capture events.
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // [3:0] pin_levels, [19:4] capture_ch0, [35:20] capture_ch1,
    // [51:36] capture_ch2, [67:52] capture_ch3, [71:68] zero.
    input  wire logic [71:0]   s_tdata,
    // Master side: filtered widths.
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [31:0] width_ch0, [63:32] width_ch1, [95:64] width_ch2, [127:96] width_ch3.
    output logic [127:0]       m_tdata,
    // [0] all_seen.
    output logic [0:0]         m_tuser,
    // Configuration: tick_prescaler.
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [15:0]   i_cfg_data
);

    logic [TickW-1:0]       r_prescaler;
    logic [PeriodW-1:0]     w_period;

    // Stage valids and the flags that ride along with the samples.
    logic                   r_v1, r_v2, r_v3, r_v4, r_vout;
    logic                   r_all2, r_all3, r_all4, r_all_out;
    logic [NumChannels-1:0] r_rng2, r_rng3, r_rng4;

    logic                   w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy_out;
    logic                   w_accept;
    logic                   w_out_load;
    t_pipe_en               w_en;

    t_tick_vec              w_capture;
    t_tick_vec              w_raw1;
    logic [NumChannels-1:0] w_rng1;
    logic                   w_all1;
    t_sample_vec            w_sample;
    t_width_vec             w_width;

    // A stage may load when it is empty or its item moves on in the same cycle.
    assign w_rdy_out  = !r_vout || m_tready;
    assign w_rdy4     = !r_v4 || w_rdy_out;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign s_tready   = w_rdy1;
    assign w_accept   = s_tvalid && w_rdy1;
    assign w_out_load = w_rdy_out && r_v4;

    assign w_en.s2 = w_rdy2;
    assign w_en.s3 = w_rdy3;
    assign w_en.s4 = w_rdy4;

    assign o_cfg_ready = 1'b1;
    assign w_period    = PeriodW'(r_prescaler) + PeriodW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescaler <= PrescalerReset;
        end else if (i_cfg_valid) begin
            r_prescaler <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (w_rdy1)    r_v1   <= s_tvalid;
            if (w_rdy2)    r_v2   <= r_v1;
            if (w_rdy3)    r_v3   <= r_v2;
            if (w_rdy4)    r_v4   <= r_v3;
            if (w_rdy_out) r_vout <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_all2 <= w_all1;
            r_rng2 <= w_rng1;
        end
        if (w_rdy3) begin
            r_all3 <= r_all2;
            r_rng3 <= r_rng2;
        end
        if (w_rdy4) begin
            r_all4 <= r_all3;
            r_rng4 <= r_rng3;
        end
        if (w_out_load) begin
            r_all_out <= r_all4;
        end
    end

    always_comb begin
        for (int i = 0; i < NumChannels; i++) begin
            w_capture[i] = s_tdata[4 + TickW*i +: TickW];
        end
    end

    rpwc_edge_capture u_edge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_load     (w_rdy1),
        .i_levels   (s_tdata[NumChannels-1:0]),
        .i_capture  (w_capture),
        .o_raw      (w_raw1),
        .o_in_range (w_rng1),
        .o_all      (w_all1)
    );

    for (genvar g = 0; g < NumChannels; g++) begin : g_conv
        rpwc_tick_convert u_conv (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_ticks  (w_raw1[g]),
            .i_period (w_period),
            .o_sample (w_sample[g])
        );
    end

    rpwc_filter_out u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_update (r_rng4 & {NumChannels{r_all4}}),
        .i_sample (w_sample),
        .o_width  (w_width)
    );

    assign m_tvalid   = r_vout;
    assign m_tdata    = w_width;
    assign m_tuser[0] = r_all_out;

    // A stalled fourth stage keeps its item.
    `RPWC_ASSERT_NEXT(a_stage4_hold, i_clk, i_rst_n, r_v4 && !w_rdy_out, r_v4, "stage 4 lost an item")
    // An accepted event always lands in the edge stage.
    `RPWC_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, w_accept, r_v1, "accepted event not captured")
    // The filter state only moves when a result is loaded.
    `RPWC_ASSERT_NEXT(a_filter_stable, i_clk, i_rst_n, !w_out_load, $stable(m_tdata), "filter changed without load")
    // No result is loaded over one that is still waiting.
    `RPWC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_vout && !m_tready, !w_out_load, "result overwritten")

endmodule

`default_nettype wire
